@@ design/task_cpu_usage_profiler_unit_macros.svh @@
// Assertion macros for the task CPU usage profiler.
// Used by the top level; expects clk and rst in scope where expanded.
`ifndef TASK_CPU_USAGE_PROFILER_UNIT_MACROS_SVH
`define TASK_CPU_USAGE_PROFILER_UNIT_MACROS_SVH
`ifndef SYNTH
`define TCPU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TCPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCPU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TCPU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/tcpu_pkg.sv @@
// Shared types and constants of the task CPU usage profiler.
// No dependencies; imported by every module of the block.
package tcpu_pkg;

  localparam int TICK_W     = 64;
  localparam int SCALE_W    = 20;
  localparam int USAGE_W    = 32;
  localparam int TASK_W     = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = TICK_W + SCALE_W;
  localparam int HALF_W     = TICK_W / 2;
  localparam int PART_W     = HALF_W + SCALE_W;

  localparam int DEF_MAX_TASKS = 16;
  localparam int JOBQ_DEPTH    = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXIT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_USAGE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETAIN_MODE = 2'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_index;
    logic              query_system;
    logic [TICK_W-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [USAGE_W-1:0] usage;
    logic               divide_by_zero;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic [TICK_W-1:0] div_ticks;
  } job_t;

endpackage

@@ design/tcpu_front.sv @@
// Front end: accepts events, keeps the per-task tick tables and session state,
// and turns each query into a divide job. Depends on tcpu_pkg.
module tcpu_front import tcpu_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  logic     retain_mode,
  output logic     job_push,
  output job_t     job,
  input  logic     job_full
);

  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TOT_DEPTH = 2 * (2 ** IDX_W);

  localparam logic [1:0] F_IDLE   = 2'd0;
  localparam logic [1:0] F_RD     = 2'd1;
  localparam logic [1:0] F_OPEN   = 2'd2;
  localparam logic [1:0] F_COMMIT = 2'd3;

  logic [1:0]        state;
  in_item_t          item;
  logic [TASK_W-1:0] running_task;
  logic              run_valid;
  logic              bank;
  logic [TICK_W-1:0] sys_total;
  logic [TICK_W-1:0] sys_start;
  logic [TICK_W-1:0] base_tick;
  logic [TICK_W-1:0] sys_saved;
  logic [TICK_W-1:0] saved_len;
  logic [TICK_W-1:0] open_ticks;
  logic [TICK_W-1:0] base_ticks;
  logic [TICK_W-1:0] div_tick;

  // Totals live in two banks: the active session and the saved one.
  // A statistics reset flips the bank and invalidates the new active bank.
  logic [TICK_W-1:0] start_mem [MAX_TASKS];
  logic [TICK_W-1:0] total_mem [TOT_DEPTH];
  logic [MAX_TASKS-1:0]      start_vld;
  logic [1:0][MAX_TASKS-1:0] tot_vld;
  logic [TICK_W-1:0] start_rd;
  logic [TICK_W-1:0] total_rd;
  logic              start_rd_vld;
  logic              total_rd_vld;

  logic              is_entry;
  logic              is_exit;
  logic              is_reset;
  logic              is_query;
  logic              idx_ok;
  logic [IDX_W-1:0]  idx_addr;
  logic [IDX_W-1:0]  rt_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_bank;
  logic              start_we;
  logic [IDX_W-1:0]  start_waddr;
  logic              total_we;
  logic [TICK_W-1:0] tick_sum;
  logic [TICK_W-1:0] start_val;
  logic [TICK_W-1:0] total_val;
  logic              use_open;

  assign is_entry = (item.kind == KIND_ENTRY);
  assign is_exit  = (item.kind == KIND_EXIT);
  assign is_reset = (item.kind == KIND_RESET);
  assign is_query = (item.kind == KIND_QUERY);
  assign idx_ok   = (32'(item.task_index) < MAX_TASKS);
  assign idx_addr = IDX_W'(item.task_index);
  assign rt_addr  = IDX_W'(running_task);
  assign rd_addr  = is_exit ? rt_addr : idx_addr;
  assign rd_bank  = (is_exit || !retain_mode) ? bank : ~bank;

  assign start_we    = (state == F_RD) && ((is_entry && idx_ok) || (is_reset && run_valid));
  assign start_waddr = is_entry ? idx_addr : rt_addr;
  assign total_we    = (state == F_COMMIT) && is_exit;
  assign tick_sum    = base_ticks + open_ticks;

  assign start_val = start_rd_vld ? start_rd : '0;
  assign total_val = total_rd_vld ? total_rd : '0;
  assign use_open  = is_exit || (!retain_mode && !item.query_system && idx_ok &&
                                 run_valid && (running_task == item.task_index));

  assign full           = (state != F_IDLE);
  assign job_push       = (state == F_COMMIT) && is_query && !job_full;
  assign job.ticks      = tick_sum;
  assign job.div_ticks  = div_tick;

  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_waddr] <= item.now_tick;
    end
    if (total_we) begin
      total_mem[{bank, rt_addr}] <= tick_sum;
    end
    start_rd <= start_mem[rd_addr];
    total_rd <= total_mem[{rd_bank, rd_addr}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vld    <= '0;
      tot_vld      <= '0;
      start_rd_vld <= 1'b0;
      total_rd_vld <= 1'b0;
    end else begin
      if (start_we) begin
        start_vld[start_waddr] <= 1'b1;
      end
      if (total_we) begin
        tot_vld[bank][rt_addr] <= 1'b1;
      end
      if ((state == F_RD) && is_reset) begin
        tot_vld[~bank] <= '0;
      end
      start_rd_vld <= start_vld[rd_addr];
      total_rd_vld <= tot_vld[rd_bank][rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      running_task <= '0;
      run_valid    <= 1'b0;
      bank         <= 1'b0;
      sys_total    <= '0;
      sys_start    <= '0;
      base_tick    <= '0;
      sys_saved    <= '0;
      saved_len    <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_RD;
          end
        end
        F_RD: begin
          unique case (item.kind)
            KIND_ENTRY: begin
              if (idx_ok) begin
                running_task <= item.task_index;
                run_valid    <= 1'b1;
                sys_total    <= sys_total + (item.now_tick - sys_start);
              end
              state <= F_IDLE;
            end
            KIND_EXIT: begin
              state <= run_valid ? F_OPEN : F_IDLE;
            end
            KIND_RESET: begin
              saved_len <= item.now_tick - base_tick;
              base_tick <= item.now_tick;
              sys_saved <= sys_total;
              sys_total <= '0;
              bank      <= ~bank;
              if (!run_valid) begin
                sys_start <= item.now_tick;
              end
              state <= F_IDLE;
            end
            KIND_QUERY: begin
              state <= F_OPEN;
            end
          endcase
        end
        F_OPEN: begin
          state <= F_COMMIT;
        end
        F_COMMIT: begin
          if (is_exit) begin
            sys_start <= item.now_tick;
            run_valid <= 1'b0;
            state     <= F_IDLE;
          end else if (!job_full) begin
            state <= F_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == F_IDLE) && push) begin
      item <= in_data;
    end
    if (state == F_OPEN) begin
      open_ticks <= use_open ? (item.now_tick - start_val) : '0;
      if (is_exit) begin
        base_ticks <= total_val;
      end else if (item.query_system) begin
        base_ticks <= retain_mode ? sys_saved : sys_total;
      end else begin
        base_ticks <= idx_ok ? total_val : '0;
      end
      div_tick <= retain_mode ? saved_len : (item.now_tick - base_tick);
    end
  end

endmodule

@@ design/tcpu_job_queue.sv @@
// Short queue of divide jobs between the front end and the divider.
// Depends on tcpu_pkg for the job type and depth.
module tcpu_job_queue import tcpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  job_t din,
  input  logic pop,
  output logic empty,
  output job_t dout
);

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/tcpu_back.sv @@
// Back end: scales the tick count, divides by the session length one quotient
// bit per cycle, saturates, and holds the result for the consumer. Uses tcpu_pkg.
module tcpu_back import tcpu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_empty,
  output logic               job_pop,
  input  job_t               job,
  input  logic [SCALE_W-1:0] usage_scale,
  output logic               empty,
  input  logic               pop,
  output result_t            result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL0 = 3'd1;
  localparam logic [2:0] B_MUL1 = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_CHK  = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  localparam int CNT_W = $clog2(USAGE_W);
  localparam int CMP_W = TICK_W + USAGE_W;

  logic [2:0]         bstate;
  logic [CNT_W-1:0]   cnt;
  logic               res_valid;
  logic [TICK_W-1:0]  ticks;
  logic [TICK_W-1:0]  div;
  logic [PART_W-1:0]  p0;
  logic [PART_W-1:0]  p1;
  logic [PROD_W-1:0]  prod;
  logic [TICK_W-1:0]  rem;
  logic [USAGE_W-1:0] low;
  logic               dz;
  logic               saturate;
  logic [TICK_W:0]    rem_s;
  logic               ge;
  logic               res_write;

  assign job_pop   = (bstate == B_IDLE) && !job_empty;
  assign empty     = !res_valid;
  assign res_write = (bstate == B_DONE) && (!res_valid || pop);

  // The quotient overflows 32 bits exactly when the product reaches div * 2^32.
  assign saturate = ({{(CMP_W-PROD_W){1'b0}}, prod} >= {div, {USAGE_W{1'b0}}});
  assign rem_s    = {rem, low[USAGE_W-1]};
  assign ge       = (rem_s >= {1'b0, div});

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_write || (res_valid && !pop);
      unique case (bstate)
        B_IDLE: begin
          if (!job_empty) begin
            bstate <= B_MUL0;
          end
        end
        B_MUL0: bstate <= B_MUL1;
        B_MUL1: bstate <= B_SUM;
        B_SUM:  bstate <= B_CHK;
        B_CHK: begin
          cnt    <= '0;
          bstate <= ((div == '0) || saturate) ? B_DONE : B_DIV;
        end
        B_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(USAGE_W - 1)) begin
            bstate <= B_DONE;
          end
        end
        B_DONE: begin
          if (res_write) begin
            bstate <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (bstate)
      B_IDLE: begin
        ticks <= job.ticks;
        div   <= job.div_ticks;
      end
      B_MUL0: p0 <= PART_W'(ticks[HALF_W-1:0]) * PART_W'(usage_scale);
      B_MUL1: p1 <= PART_W'(ticks[TICK_W-1:HALF_W]) * PART_W'(usage_scale);
      B_SUM:  prod <= {p1, {HALF_W{1'b0}}} + PROD_W'(p0);
      B_CHK: begin
        dz <= (div == '0);
        if (div == '0) begin
          low <= '0;
        end else if (saturate) begin
          low <= '1;
        end else begin
          rem <= TICK_W'(prod[PROD_W-1:USAGE_W]);
          low <= prod[USAGE_W-1:0];
        end
      end
      B_DIV: begin
        rem <= ge ? TICK_W'(rem_s - {1'b0, div}) : rem_s[TICK_W-1:0];
        low <= {low[USAGE_W-2:0], ge};
      end
      B_DONE: begin
        if (res_write) begin
          result.usage          <= low;
          result.divide_by_zero <= dz;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/task_cpu_usage_profiler_unit.sv @@
// Task CPU usage profiler. Entry, statistics-reset and system-context exit events hold the
// front end through its read state; exits of a running task and queries also through its
// open and commit states (a query longer while the job queue is full). The back end takes
// a new query only once the last result is written, skips the divide on a zero divisor or
// saturation, and divides one quotient bit per cycle; a 2-deep job queue lets the front
// end run ahead. Synchronous reset clears the control state and valid flags at once.
`include "task_cpu_usage_profiler_unit_macros.svh"

module task_cpu_usage_profiler_unit import tcpu_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0] usage_scale;
  logic               retain_mode;
  logic               jq_push;
  logic               jq_full;
  logic               jq_pop;
  logic               jq_empty;
  job_t               jq_in;
  job_t               jq_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      usage_scale <= SCALE_RESET;
      retain_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USAGE_SCALE: usage_scale <= cfg_data[SCALE_W-1:0];
        CFG_RETAIN_MODE: retain_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tcpu_front #(
    .MAX_TASKS(MAX_TASKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .retain_mode (retain_mode),
    .job_push    (jq_push),
    .job         (jq_in),
    .job_full    (jq_full)
  );

  tcpu_job_queue u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .full  (jq_full),
    .din   (jq_in),
    .pop   (jq_pop),
    .empty (jq_empty),
    .dout  (jq_out)
  );

  tcpu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_empty   (jq_empty),
    .job_pop     (jq_pop),
    .job         (jq_out),
    .usage_scale (usage_scale),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  `TCPU_ASSERT_IMPLY(a_no_push_when_full, jq_push, !jq_full, "job pushed into a full queue")
  `TCPU_ASSERT_IMPLY(a_no_pop_when_empty, jq_pop, !jq_empty, "job popped from an empty queue")
  `TCPU_ASSERT_NEXT(a_busy_after_accept, push && !full, full, "front end took a second event")
  `TCPU_ASSERT_IMPLY(a_dz_zero_usage, !empty && result.divide_by_zero, result.usage == '0, "nonzero usage on zero divisor")

endmodule
